@@ hw/rtl/intel_hex_record_parser_assert.svh @@
// assertion macros for the record parser, included by ihex_parse
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define IHEX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define IHEX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ihex_pkg.sv @@
// types, codes and helpers of the hex record parser
package ihex_pkg;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_HEADER = 3'd1,
		PH_DATA   = 3'd2,
		PH_CKSUM  = 3'd3,
		PH_EOL    = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		K_DATA    = 3'd0,
		K_OK      = 3'd1,
		K_END     = 3'd2,
		K_BADSUM  = 3'd3,
		K_NOCOLON = 3'd4,
		K_NOEOL   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		FLD_COUNT  = 2'd0,
		FLD_ADDR_H = 2'd1,
		FLD_ADDR_L = 2'd2,
		FLD_TYPE   = 2'd3
	} field_t;

	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] REC_TYPE_END = 8'h01;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] address;
		logic [7:0]  data_byte;
		logic        last;
	} result_t;

	// ascii hex digit to nibble, anything else reads as zero
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c - 8'h30;
		end else if (c inside {[8'h41:8'h46]}) begin
			v = c - 8'h37;
		end else if (c inside {[8'h61:8'h66]}) begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

endpackage

@@ hw/rtl/ihex_parse.sv @@
// record parse state and the per-byte next-state and result logic
module ihex_parse
	import ihex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  char_in,
	input  logic        text_mode,
	output logic        res_valid,
	output result_t     res
);

`include "intel_hex_record_parser_assert.svh"

	phase_t      phase_q, phase_n;
	logic        second_digit_q, second_digit_n;
	logic [3:0]  high_nibble_q, high_nibble_n;
	field_t      field_index_q, field_index_n;
	logic [7:0]  bytes_left_q, bytes_left_n;
	logic [15:0] run_addr_q, run_addr_n;
	logic [7:0]  sum_q, sum_n;
	logic        sum_bad_q, sum_bad_n;
	logic        finished_q, finished_n;
	logic [15:0] rec_start_q, rec_start_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_START;
			second_digit_q <= 1'b0;
			high_nibble_q  <= 4'd0;
			field_index_q  <= FLD_COUNT;
			bytes_left_q   <= 8'd0;
			run_addr_q     <= 16'd0;
			sum_q          <= 8'd0;
			sum_bad_q      <= 1'b0;
			finished_q     <= 1'b0;
			rec_start_q    <= 16'd0;
		end else if (step) begin
			phase_q        <= phase_n;
			second_digit_q <= second_digit_n;
			high_nibble_q  <= high_nibble_n;
			field_index_q  <= field_index_n;
			bytes_left_q   <= bytes_left_n;
			run_addr_q     <= run_addr_n;
			sum_q          <= sum_n;
			sum_bad_q      <= sum_bad_n;
			finished_q     <= finished_n;
			rec_start_q    <= rec_start_n;
		end
	end

	always_comb begin
		phase_t     ph;
		logic       go;
		logic       oct_ok;
		logic [7:0] oct;
		logic [7:0] sum_tmp;
		logic [7:0] left_tmp;

		phase_n        = phase_q;
		second_digit_n = second_digit_q;
		high_nibble_n  = high_nibble_q;
		field_index_n  = field_index_q;
		bytes_left_n   = bytes_left_q;
		run_addr_n     = run_addr_q;
		sum_n          = sum_q;
		sum_bad_n      = sum_bad_q;
		finished_n     = finished_q;
		rec_start_n    = rec_start_q;
		res_valid      = 1'b0;
		res            = '0;
		ph             = phase_q;
		go             = 1'b0;
		oct_ok         = 1'b0;
		oct            = char_in;
		sum_tmp        = 8'd0;
		left_tmp       = 8'd0;

		if (finished_q) begin
			go = 1'b0;
		end else if (phase_q == PH_EOL) begin
			res_valid   = 1'b1;
			res.address = rec_start_q;
			res.last    = 1'b1;
			if (char_in == CHAR_NEWLINE) begin
				phase_n  = PH_START;
				res.kind = sum_bad_q ? K_BADSUM : K_OK;
			end else begin
				finished_n = 1'b1;
				res.kind   = K_NOEOL;
			end
		end else if (phase_q == PH_START) begin
			field_index_n  = FLD_COUNT;
			second_digit_n = 1'b0;
			if (text_mode) begin
				if (char_in == CHAR_COLON) begin
					phase_n = PH_HEADER;
				end else begin
					finished_n = 1'b1;
					res_valid  = 1'b1;
					res.kind   = K_NOCOLON;
					res.last   = 1'b1;
				end
			end else begin
				// raw octets need no start mark
				ph      = PH_HEADER;
				phase_n = PH_HEADER;
				go      = 1'b1;
			end
		end else begin
			go = 1'b1;
		end

		if (go) begin
			if (text_mode) begin
				if (!second_digit_q || ph != phase_q) begin
					high_nibble_n  = hex_digit(char_in);
					second_digit_n = 1'b1;
				end else begin
					second_digit_n = 1'b0;
					oct            = {high_nibble_q, hex_digit(char_in)};
					oct_ok         = 1'b1;
				end
			end else begin
				second_digit_n = 1'b0;
				oct_ok         = 1'b1;
			end
		end

		if (oct_ok) begin
			case (ph)
				PH_HEADER: begin
					sum_n = ((field_index_n == FLD_COUNT) ? 8'd0 : sum_q) + oct;
					field_index_n = field_t'(field_index_n + 2'd1);
					case (ph == phase_q ? field_index_q : FLD_COUNT)
						FLD_COUNT: bytes_left_n = oct;
						FLD_ADDR_H: run_addr_n = {oct, 8'd0};
						FLD_ADDR_L: begin
							run_addr_n  = run_addr_q | {8'd0, oct};
							rec_start_n = run_addr_q | {8'd0, oct};
						end
						FLD_TYPE: begin
							if (oct == REC_TYPE_END) begin
								finished_n    = 1'b1;
								field_index_n = field_index_q;
								res_valid     = 1'b1;
								res.kind      = K_END;
								res.address   = rec_start_q;
								res.last      = 1'b1;
							end else begin
								phase_n = (bytes_left_q != 8'd0) ? PH_DATA : PH_CKSUM;
							end
						end
						default: bytes_left_n = bytes_left_q;
					endcase
				end
				PH_DATA: begin
					left_tmp      = bytes_left_q - 8'd1;
					sum_n         = sum_q + oct;
					run_addr_n    = run_addr_q + 16'd1;
					bytes_left_n  = left_tmp;
					if (left_tmp == 8'd0) begin
						phase_n = PH_CKSUM;
					end
					res_valid     = 1'b1;
					res.kind      = K_DATA;
					res.address   = run_addr_q;
					res.data_byte = oct;
				end
				PH_CKSUM: begin
					sum_tmp   = sum_q + oct;
					sum_n     = sum_tmp;
					sum_bad_n = (sum_tmp != 8'd0);
					if (text_mode) begin
						phase_n = PH_EOL;
					end else begin
						phase_n     = PH_START;
						res_valid   = 1'b1;
						res.kind    = (sum_tmp != 8'd0) ? K_BADSUM : K_OK;
						res.address = rec_start_q;
						res.last    = 1'b1;
					end
				end
				default: phase_n = phase_q;
			endcase
		end
	end

	// done state holds until reset and produces nothing
	`IHEX_ASSERT_NEXT(a_finished_sticky, finished_q, finished_q, "finished state was left")
	`IHEX_ASSERT_NOW(a_finished_quiet, finished_q, !res_valid, "result after finish")
	// end of line is only awaited on a whole octet boundary
	`IHEX_ASSERT_NOW(a_eol_aligned, phase_q == PH_EOL, !second_digit_q,
		"half octet pending at end of line")

endmodule

@@ hw/rtl/intel_hex_record_parser.sv @@
// an accepted byte waits in the input register, and its result is then held in the result register
// throughput: one stream byte per cycle while the result register has room, as the parse step is combinational
// the input register and the result register are separate, so a byte is taken
// while an earlier result waits on m_tready
// reset (arst_n low, asynchronous): parser waits for a record start, text mode is on,
// no result pending, sticky done state cleared
module intel_hex_record_parser
	import ihex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel, text_mode in bit 0
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	// results out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] address, [23:16] data_byte
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast    // last
);

	logic        text_mode_q;
	logic        byte_valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        res_valid;
	result_t     res;
	logic        out_valid_q;
	result_t     out_q;

	// configuration is always writable; the user must write it only while idle, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_mode_q <= 1'b1;
		end else if (cfg_valid) begin
			text_mode_q <= cfg_data;
		end
	end

	// the held byte is parsed once the result register has room
	assign advance  = byte_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !byte_valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			byte_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// parser state and per-byte decode
	ihex_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_in   (byte_s1),
		.text_mode (text_mode_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register, bytes that give no result leave it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.data_byte, out_q.address};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

endmodule
